// File: rtl/ppd_pkg.sv
`default_nettype none
package ppd_pkg;

  localparam int CAP_W   = 16;
  localparam int WIDTH_W = 15;
  localparam int GAIN_W  = 6;
  localparam int FAC_W   = 7;
  localparam int DIFF_W  = 11;
  localparam int PROD_W  = 16;
  localparam int IDX_W   = 3;
  localparam int VAL_W   = 13;
  localparam int QUO_W   = 12;

  localparam logic [WIDTH_W-1:0] SYNC_LOW   = 15'd4000;
  localparam logic [WIDTH_W-1:0] SYNC_HIGH  = 15'd19000;
  localparam logic [WIDTH_W-1:0] PULSE_LOW  = 15'd800;
  localparam logic [WIDTH_W-1:0] PULSE_HIGH = 15'd2200;
  localparam logic signed [VAL_W-1:0] PULSE_CENTRE = 13'sd1500;
  localparam logic signed [FAC_W-1:0] GAIN_BASE    = 7'sd10;

  // floor(x * RECIP_10 / 2^RECIP_SHIFT) == floor(x / 10) for x < 2^18
  localparam logic [16:0] RECIP_10    = 17'd52429;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DIFF_W-1:0] diff;
  } ppd_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [PROD_W-1:0] prod;
  } ppd_prod_t;

endpackage
`default_nettype wire

// File: rtl/ppd_front.sv
`default_nettype none
module ppd_front #(
  parameter int NUM_CHANNELS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [ppd_pkg::CAP_W-1:0]    in_tdata,
  output logic                              s1_valid,
  output ppd_pkg::ppd_beat_t                s1_beat,
  input  wire logic                         s1_ready
);

  localparam int SLOT_W = $clog2(NUM_CHANNELS + 2);
  localparam logic [SLOT_W-1:0] SLOT_IDLE  = '0;
  localparam logic [SLOT_W-1:0] SLOT_FIRST = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(NUM_CHANNELS);

  logic [ppd_pkg::CAP_W-1:0]   prev_r;
  logic [SLOT_W-1:0]           slot_r, slot_nxt;
  logic                        s1_valid_r, s1_valid_nxt;
  ppd_pkg::ppd_beat_t          s1_beat_r, s1_beat_nxt;

  logic [ppd_pkg::CAP_W-1:0]   delta;
  logic [ppd_pkg::WIDTH_W-1:0] width;
  logic                        is_sync, is_pulse, armed, accept;
  logic signed [ppd_pkg::VAL_W-1:0] diff_full;
  logic [SLOT_W-1:0]           slot_m1;

  assign in_tready = !s1_valid_r || s1_ready;
  assign accept    = in_tvalid && in_tready;

  assign delta     = in_tdata - prev_r;
  assign width     = delta[ppd_pkg::CAP_W-1:1];
  assign is_sync   = (width > ppd_pkg::SYNC_LOW) && (width < ppd_pkg::SYNC_HIGH);
  assign is_pulse  = (width > ppd_pkg::PULSE_LOW) && (width < ppd_pkg::PULSE_HIGH);
  assign armed     = (slot_r >= SLOT_FIRST) && (slot_r <= SLOT_LAST);
  assign diff_full = $signed({1'b0, width[ppd_pkg::VAL_W-2:0]}) - ppd_pkg::PULSE_CENTRE;
  assign slot_m1   = slot_r - SLOT_FIRST;

  always_comb begin
    slot_nxt     = slot_r;
    s1_valid_nxt = s1_valid_r && !s1_ready;
    s1_beat_nxt  = s1_beat_r;
    if (accept) begin
      s1_valid_nxt = 1'b0;
      if (is_sync) begin
        slot_nxt = SLOT_FIRST;
      end else if (armed) begin
        if (is_pulse) begin
          s1_valid_nxt     = 1'b1;
          s1_beat_nxt.idx  = ppd_pkg::IDX_W'(slot_m1);
          s1_beat_nxt.diff = diff_full[ppd_pkg::DIFF_W-1:0];
          slot_nxt         = slot_r + SLOT_FIRST;
        end else begin
          slot_nxt = SLOT_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      slot_r     <= SLOT_IDLE;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        prev_r <= in_tdata;
      end
      slot_r     <= slot_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
    s1_beat_r <= s1_beat_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_beat  = s1_beat_r;

endmodule
`default_nettype wire

// File: rtl/ppd_scale.sv
`default_nettype none
module ppd_scale (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic signed [ppd_pkg::GAIN_W-1:0]   gain,
  input  wire logic                                s1_valid,
  input  wire ppd_pkg::ppd_beat_t                  s1_beat,
  output logic                                     s1_ready,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [ppd_pkg::IDX_W+ppd_pkg::VAL_W-1:0] out_tdata
);

  logic                       s2_valid_r;
  ppd_pkg::ppd_prod_t         s2_r;
  logic                       o_valid_r;
  logic [ppd_pkg::IDX_W-1:0]  o_idx_r;
  logic signed [ppd_pkg::VAL_W-1:0] o_val_r;

  logic                       o_ready, s2_ready;
  logic signed [ppd_pkg::FAC_W-1:0] factor;
  logic signed [ppd_pkg::DIFF_W+ppd_pkg::FAC_W-1:0] prod_full;
  logic                       neg;
  logic [ppd_pkg::PROD_W-1:0] mag;
  logic [31:0]                recip_prod;
  logic [ppd_pkg::QUO_W-1:0]  quo;
  logic [ppd_pkg::VAL_W-1:0]  quo_ext;
  logic signed [ppd_pkg::VAL_W-1:0] val;

  assign o_ready  = !o_valid_r || out_tready;
  assign s2_ready = !s2_valid_r || o_ready;
  assign s1_ready = s2_ready;

  // Scale: (gain + 10) times the offset from center
  assign factor    = {gain[ppd_pkg::GAIN_W-1], gain} + ppd_pkg::GAIN_BASE;
  assign prod_full = s1_beat.diff * factor;

  // Divide magnitude by ten, then restore the sign (truncate toward zero)
  assign neg        = s2_r.prod[ppd_pkg::PROD_W-1];
  assign mag        = neg ? (-s2_r.prod) : s2_r.prod;
  assign recip_prod = {17'd0, mag[ppd_pkg::PROD_W-2:0]} * {15'd0, ppd_pkg::RECIP_10};
  assign quo        = recip_prod[ppd_pkg::RECIP_SHIFT +: ppd_pkg::QUO_W];
  assign quo_ext    = {1'b0, quo};
  assign val        = neg ? $signed(-quo_ext) : $signed(quo_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_r <= s1_valid;
      end
      if (o_ready) begin
        o_valid_r <= s2_valid_r;
      end
    end
    if (s2_ready && s1_valid) begin
      s2_r.idx  <= s1_beat.idx;
      s2_r.prod <= prod_full[ppd_pkg::PROD_W-1:0];
    end
    if (o_ready && s2_valid_r) begin
      o_idx_r <= s2_r.idx;
      o_val_r <= val;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = {o_val_r, o_idx_r};

endmodule
`default_nettype wire

// File: rtl/ppm_pulse_train_decoder_core.sv
`default_nettype none
// Channel  | Dir | Ports                       | Beat content
// ---------+-----+-----------------------------+------------------------------------
// input    | in  | in_tvalid/tready/tdata      | capture_time[15:0], 0.5 us ticks
// result   | out | out_tvalid/tready/tdata     | channel_index[2:0], channel_value[15:3]
// config   | in  | cfg_valid/ready/data        | gain_adjust[5:0], signed
//
// One capture beat per cycle while in_tready is high. Width, sync/pulse
// decode and slot update happen as the beat is taken; a decoded channel
// then passes the gain multiplier stage and the divide-by-ten stage before
// it reaches the result register. Beats that yield no channel leave nothing.
// Reset (synchronous, rst_n low) clears the slot, the previous capture and
// gain_adjust. Each stage holds under out_tready low and fills empty stages,
// so in_tready drops only when all three stages hold a channel.
module ppm_pulse_train_decoder_core #(
  parameter int NUM_CHANNELS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,    // [15:0] capture_time
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // [2:0] channel_index, [15:3] channel_value
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [5:0]  cfg_data     // [5:0] gain_adjust
);

  logic signed [ppd_pkg::GAIN_W-1:0] gain_r;
  logic                              s1_valid, s1_ready;
  ppd_pkg::ppd_beat_t                s1_beat;

  // Register write is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
    end else if (cfg_valid) begin
      gain_r <= $signed(cfg_data);
    end
  end

  // Decode widths, track the frame slot
  ppd_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .s1_valid (s1_valid),
    .s1_beat  (s1_beat),
    .s1_ready (s1_ready)
  );

  // Apply gain and divide by ten, drive the result register
  ppd_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .gain      (gain_r),
    .s1_valid  (s1_valid),
    .s1_beat   (s1_beat),
    .s1_ready  (s1_ready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule
`default_nettype wire
